FILE: rtl/ntm_pkg.sv
// ----------------------------------------------------------------------------
// ntm_pkg
// Shared types and constants for the nearest timestamp matcher.
// ----------------------------------------------------------------------------
package ntm_pkg;

    localparam int STAMP_BITS     = 63;
    localparam int FRAME_TAG_BITS = 16;
    localparam int DIFF_BITS      = 64;
    localparam int BATCH_BITS     = 8;
    localparam int PADDR_BITS     = 3;
    localparam int PDATA_BITS     = 32;

    localparam logic [BATCH_BITS-1:0] BATCH_RESET = 8'd5;

    // register index, taken from paddr above the byte offset
    localparam logic REG_BATCH_SIZE = 1'b0;

    localparam logic ACTION_DEPTH = 1'b0;
    localparam logic ACTION_POSE  = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        logic push;
        logic rotate;
    } t_queue_ctrl;

    typedef struct packed {
        logic                        action;
        logic [STAMP_BITS-1:0]       stamp_ns;
        logic [FRAME_TAG_BITS-1:0]   frame_tag;
    } t_in_item;

    typedef struct packed {
        logic [FRAME_TAG_BITS-1:0]   pose_tag;
        logic [FRAME_TAG_BITS-1:0]   depth_tag;
        logic signed [DIFF_BITS-1:0] time_difference_ns;
    } t_out_item;

endpackage

FILE: rtl/ntm_cell.sv
// ----------------------------------------------------------------------------
// ntm_cell
// One queue slot: holds a stamp and a tag, loads a new entry or takes its
// neighbor's entry.
// ----------------------------------------------------------------------------
module ntm_cell #(
    parameter int TAG_BITS = 16
) (
    input  logic                          i_clk,
    input  ntm_pkg::t_cell_op             i_op,
    input  logic [ntm_pkg::STAMP_BITS-1:0] i_new_stamp,
    input  logic [TAG_BITS-1:0]           i_new_tag,
    input  logic [ntm_pkg::STAMP_BITS-1:0] i_next_stamp,
    input  logic [TAG_BITS-1:0]           i_next_tag,
    output logic [ntm_pkg::STAMP_BITS-1:0] o_stamp,
    output logic [TAG_BITS-1:0]           o_tag
);
    import ntm_pkg::*;

    logic [STAMP_BITS-1:0] r_stamp;
    logic [TAG_BITS-1:0]   r_tag;

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_LOAD: begin
                r_stamp <= i_new_stamp;
                r_tag   <= i_new_tag;
            end
            CELL_SHIFT: begin
                r_stamp <= i_next_stamp;
                r_tag   <= i_next_tag;
            end
            default: begin
                r_stamp <= r_stamp;
                r_tag   <= r_tag;
            end
        endcase
    end

    assign o_stamp = r_stamp;
    assign o_tag   = r_tag;

endmodule

FILE: rtl/ntm_queue.sv
// ----------------------------------------------------------------------------
// ntm_queue
// Row of cells forming a bounded queue, oldest at cell 0. A push into a full
// queue shifts out the oldest; a rotate moves every cell one place toward 0.
// ----------------------------------------------------------------------------
module ntm_queue #(
    parameter int DEPTH    = 10,
    parameter int TAG_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ntm_pkg::t_queue_ctrl           i_ctrl,
    input  logic [ntm_pkg::STAMP_BITS-1:0] i_stamp,
    input  logic [TAG_BITS-1:0]            i_tag,
    output logic [$clog2(DEPTH+1)-1:0]     o_count,
    output logic [ntm_pkg::STAMP_BITS-1:0] o_head_stamp,
    output logic [TAG_BITS-1:0]            o_head_tag
);
    import ntm_pkg::*;

    localparam int CNT_BITS = $clog2(DEPTH+1);

    logic [CNT_BITS-1:0]   r_count;
    logic [CNT_BITS-1:0]   n_count;
    logic                  w_full;
    logic [STAMP_BITS-1:0] w_stamp [DEPTH];
    logic [TAG_BITS-1:0]   w_tag   [DEPTH];

    assign w_full = (r_count == CNT_BITS'(DEPTH));

    always_comb begin
        n_count = r_count;
        if (i_ctrl.push && !w_full) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_op w_op;

        always_comb begin
            w_op = CELL_HOLD;
            if (i_ctrl.push) begin
                if (w_full) begin
                    w_op = (g == DEPTH-1) ? CELL_LOAD : CELL_SHIFT;
                end else if (r_count == CNT_BITS'(g)) begin
                    w_op = CELL_LOAD;
                end
            end else if (i_ctrl.rotate) begin
                w_op = CELL_SHIFT;
            end
        end

        // last cell wraps to cell 0 so a full rotation restores the order
        ntm_cell #(
            .TAG_BITS(TAG_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_new_stamp (i_stamp),
            .i_new_tag   (i_tag),
            .i_next_stamp(w_stamp[(g+1) % DEPTH]),
            .i_next_tag  (w_tag[(g+1) % DEPTH]),
            .o_stamp     (w_stamp[g]),
            .o_tag       (w_tag[g])
        );
    end

    assign o_count      = r_count;
    assign o_head_stamp = w_stamp[0];
    assign o_head_tag   = w_tag[0];

endmodule

FILE: rtl/ntm_match.sv
// ----------------------------------------------------------------------------
// ntm_match
// Two-stage nearest search: absolute difference, then compare against the
// best so far. Only a strictly smaller difference replaces the best.
// ----------------------------------------------------------------------------
module ntm_match #(
    parameter int TAG_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_en,
    input  logic [ntm_pkg::STAMP_BITS-1:0] i_pose_stamp,
    input  logic [ntm_pkg::STAMP_BITS-1:0] i_depth_stamp,
    input  logic [TAG_BITS-1:0]            i_depth_tag,
    output logic [ntm_pkg::STAMP_BITS-1:0] o_best_stamp,
    output logic [TAG_BITS-1:0]            o_best_tag
);
    import ntm_pkg::*;

    logic [STAMP_BITS:0]   w_pd;
    logic [STAMP_BITS:0]   w_dp;
    logic [STAMP_BITS-1:0] w_abs;

    logic                  r_s1_valid;
    logic [STAMP_BITS-1:0] r_s1_abs;
    logic [STAMP_BITS-1:0] r_s1_stamp;
    logic [TAG_BITS-1:0]   r_s1_tag;

    logic                  r_found;
    logic [STAMP_BITS-1:0] r_best_abs;
    logic [STAMP_BITS-1:0] r_best_stamp;
    logic [TAG_BITS-1:0]   r_best_tag;
    logic                  w_take;

    assign w_pd  = {1'b0, i_pose_stamp} - {1'b0, i_depth_stamp};
    assign w_dp  = {1'b0, i_depth_stamp} - {1'b0, i_pose_stamp};
    // borrow out of pose minus depth means depth is later
    assign w_abs = w_pd[STAMP_BITS] ? w_dp[STAMP_BITS-1:0] : w_pd[STAMP_BITS-1:0];

    assign w_take = r_s1_valid && (!r_found || (r_s1_abs < r_best_abs));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_s1_valid <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_s1_valid <= i_en;
            if (w_take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_abs   <= w_abs;
        r_s1_stamp <= i_depth_stamp;
        r_s1_tag   <= i_depth_tag;
        if (w_take) begin
            r_best_abs   <= r_s1_abs;
            r_best_stamp <= r_s1_stamp;
            r_best_tag   <= r_s1_tag;
        end
    end

    assign o_best_stamp = r_best_stamp;
    assign o_best_tag   = r_best_tag;

endmodule

FILE: rtl/nearest_timestamp_matcher_top.sv
// ----------------------------------------------------------------------------
// nearest_timestamp_matcher_top
// An item that triggers no match, or finds a queue empty, never raises stall.
// A matching item holds stall through the scan, flush and emit states, with
// the depth queue rotating past the compare unit one entry per cycle; its
// result is registered and made valid in the emit state, which waits out
// any output stall.
// Synchronous reset empties both queues, clears the arrival count, drops any
// pending result and sets batch_size to 5.
// ----------------------------------------------------------------------------
module nearest_timestamp_matcher_top #(
    parameter int QUEUE_DEPTH = 10,
    parameter int TAG_BITS    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ntm_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ntm_pkg::t_out_item             o_out_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ntm_pkg::PADDR_BITS-1:0] paddr,
    input  logic [ntm_pkg::PDATA_BITS-1:0] pwdata,
    output logic [ntm_pkg::PDATA_BITS-1:0] prdata,
    output logic                           pready
);
    import ntm_pkg::*;

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH+1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [CNT_BITS-1:0]   r_step;
    logic [BATCH_BITS-1:0] r_counter;
    logic [BATCH_BITS-1:0] r_batch_size;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  w_accept;
    logic [BATCH_BITS-1:0] w_count_inc;
    logic                  w_due;
    logic                  w_pose_any;
    logic                  w_depth_any;
    logic                  w_start;
    logic                  w_out_free;
    logic                  w_reg_sel;

    t_queue_ctrl           w_pose_ctrl;
    t_queue_ctrl           w_depth_ctrl;
    logic [TAG_BITS-1:0]   w_in_tag;
    logic [TAG_BITS+FRAME_TAG_BITS-1:0] w_in_tag_ext;

    logic [CNT_BITS-1:0]   w_pose_count;
    logic [CNT_BITS-1:0]   w_depth_count;
    logic [STAMP_BITS-1:0] w_pose_stamp;
    logic [TAG_BITS-1:0]   w_pose_tag;
    logic [STAMP_BITS-1:0] w_depth_stamp;
    logic [TAG_BITS-1:0]   w_depth_tag;
    logic [STAMP_BITS-1:0] w_best_stamp;
    logic [TAG_BITS-1:0]   w_best_tag;
    logic [TAG_BITS+FRAME_TAG_BITS-1:0] w_pose_tag_ext;
    logic [TAG_BITS+FRAME_TAG_BITS-1:0] w_best_tag_ext;
    logic [DIFF_BITS-1:0]  w_diff;

    // configuration port
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[PADDR_BITS-1] == REG_BATCH_SIZE);
    assign prdata    = w_reg_sel ? {{(PDATA_BITS-BATCH_BITS){1'b0}}, r_batch_size} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_size <= BATCH_RESET;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_batch_size <= pwdata[BATCH_BITS-1:0];
        end
    end

    // arrival handling
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_count_inc = r_counter + 1'b1;
    assign w_due       = (w_count_inc >= r_batch_size);
    assign w_pose_any  = (i_in_item.action == ACTION_POSE) || (w_pose_count != '0);
    assign w_depth_any = (i_in_item.action == ACTION_DEPTH) || (w_depth_count != '0);
    assign w_start     = w_accept && w_due && w_pose_any && w_depth_any;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_in_tag_ext = {{TAG_BITS{1'b0}}, i_in_item.frame_tag};
    assign w_in_tag     = w_in_tag_ext[TAG_BITS-1:0];

    assign w_pose_ctrl.push    = w_accept && (i_in_item.action == ACTION_POSE);
    assign w_pose_ctrl.rotate  = 1'b0;
    assign w_depth_ctrl.push   = w_accept && (i_in_item.action == ACTION_DEPTH);
    assign w_depth_ctrl.rotate = (r_state == S_SCAN);

    ntm_queue #(
        .DEPTH   (QUEUE_DEPTH),
        .TAG_BITS(TAG_BITS)
    ) u_pose_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_pose_ctrl),
        .i_stamp     (i_in_item.stamp_ns),
        .i_tag       (w_in_tag),
        .o_count     (w_pose_count),
        .o_head_stamp(w_pose_stamp),
        .o_head_tag  (w_pose_tag)
    );

    ntm_queue #(
        .DEPTH   (QUEUE_DEPTH),
        .TAG_BITS(TAG_BITS)
    ) u_depth_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_depth_ctrl),
        .i_stamp     (i_in_item.stamp_ns),
        .i_tag       (w_in_tag),
        .o_count     (w_depth_count),
        .o_head_stamp(w_depth_stamp),
        .o_head_tag  (w_depth_tag)
    );

    // head of the depth queue shows entry r_step during the scan
    ntm_match #(
        .TAG_BITS(TAG_BITS)
    ) u_match (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (w_start),
        .i_en         ((r_state == S_SCAN) && (r_step < w_depth_count)),
        .i_pose_stamp (w_pose_stamp),
        .i_depth_stamp(w_depth_stamp),
        .i_depth_tag  (w_depth_tag),
        .o_best_stamp (w_best_stamp),
        .o_best_tag   (w_best_tag)
    );

    assign w_pose_tag_ext = {{FRAME_TAG_BITS{1'b0}}, w_pose_tag};
    assign w_best_tag_ext = {{FRAME_TAG_BITS{1'b0}}, w_best_tag};
    assign w_diff = {1'b0, w_pose_stamp} - {1'b0, w_best_stamp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_counter   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_EMIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_counter <= w_due ? '0 : w_count_inc;
                    end
                    if (w_start) begin
                        r_step  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == CNT_BITS'(QUEUE_DEPTH-1)) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_item.pose_tag           <= w_pose_tag_ext[FRAME_TAG_BITS-1:0];
                        r_out_item.depth_tag          <= w_best_tag_ext[FRAME_TAG_BITS-1:0];
                        r_out_item.time_difference_ns <= signed'(w_diff);
                        r_state                       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/ntm_checker.sv
// ----------------------------------------------------------------------------
// ntm_checker
// Port-level checks on the matcher's handshakes and result timing.
// ----------------------------------------------------------------------------
module ntm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input ntm_pkg::t_in_item              i_in_item,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input ntm_pkg::t_out_item             o_out_item,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [ntm_pkg::PADDR_BITS-1:0] paddr,
    input logic [ntm_pkg::PDATA_BITS-1:0] pwdata,
    input logic [ntm_pkg::PDATA_BITS-1:0] prdata,
    input logic                           pready
);
    import ntm_pkg::*;

    // reset leaves no result pending and the input open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result or stall present after reset");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // a new result only appears at the end of a scan, while input is stalled
    a_result_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared outside a scan");

    // no result can follow an accepted item in the next cycle
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result faster than the scan allows");

    // write port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("config access not ready");

endmodule

bind nearest_timestamp_matcher_top ntm_checker u_checker (.*);

FILE: verif/nearest_timestamp_matcher_top_tb.sv
// ----------------------------------------------------------------------------
// nearest_timestamp_matcher_top_tb
// Self-checking bench for the nearest timestamp matcher. Pose and depth items
// are driven over the valid/stall input channel. A local model of both bounded
// queues and the shared arrival count predicts every match result, and each
// result is compared field by field on the output channel. batch_size is
// written and read back over APB between phases, covering 0, 1 and 255.
// Both channels idle at random, except during one phase that runs at full rate.
// ----------------------------------------------------------------------------
module nearest_timestamp_matcher_top_tb;
    import ntm_pkg::*;

    localparam int QUEUE_DEPTH  = 10;
    localparam int SETTLE_CYCLES = QUEUE_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int IDLE_PCT     = 6;
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

    typedef struct packed {
        logic [STAMP_BITS-1:0]     stamp;
        logic [FRAME_TAG_BITS-1:0] tag;
    } t_sensor_entry;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    t_in_item              in_item    = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    t_out_item             out_item;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [PADDR_BITS-1:0] paddr      = '0;
    logic [PDATA_BITS-1:0] pwdata     = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    // local copy of the block state
    t_sensor_entry         pose_fifo[$];
    t_sensor_entry         depth_fifo[$];
    logic [BATCH_BITS-1:0] arrivals_since_match = '0;
    logic [BATCH_BITS-1:0] batch_now = BATCH_RESET;
    t_out_item             expected_matches[$];

    int errors   = 0;
    int accepted = 0;
    int matched  = 0;
    int cycles   = 0;
    bit calm     = 1'b0;

    nearest_timestamp_matcher_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TAG_BITS   (FRAME_TAG_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // append to the item's queue, bump the shared count, pair oldest pose
    task automatic track_arrival(input t_in_item it);
        t_sensor_entry            entry;
        t_sensor_entry            best;
        logic [STAMP_BITS-1:0]    gap;
        logic [STAMP_BITS-1:0]    best_gap;
        logic [STAMP_BITS-1:0]    pose_stamp;
        t_out_item                want;
        entry.stamp = it.stamp_ns;
        entry.tag   = it.frame_tag;
        if (it.action == ACTION_POSE) begin
            if (pose_fifo.size() == QUEUE_DEPTH) void'(pose_fifo.pop_front());
            pose_fifo = {pose_fifo, entry};
        end else begin
            if (depth_fifo.size() == QUEUE_DEPTH) void'(depth_fifo.pop_front());
            depth_fifo = {depth_fifo, entry};
        end
        accepted++;
        arrivals_since_match = arrivals_since_match + 1'b1;
        if (arrivals_since_match >= batch_now) begin
            arrivals_since_match = '0;
            if (pose_fifo.size() != 0 && depth_fifo.size() != 0) begin
                pose_stamp = pose_fifo[0].stamp;
                best       = depth_fifo[0];
                best_gap   = '0;
                for (int i = 0; i < depth_fifo.size(); i++) begin
                    gap = (pose_stamp >= depth_fifo[i].stamp) ?
                          pose_stamp - depth_fifo[i].stamp :
                          depth_fifo[i].stamp - pose_stamp;
                    // strictly smaller only, so the older entry keeps a tie
                    if (i == 0 || gap < best_gap) begin
                        best_gap = gap;
                        best     = depth_fifo[i];
                    end
                end
                want.pose_tag           = pose_fifo[0].tag;
                want.depth_tag          = best.tag;
                want.time_difference_ns = {1'b0, pose_stamp} - {1'b0, best.stamp};
                expected_matches = {expected_matches, want};
            end
        end
    endtask

    task automatic send_item(input logic action, input logic [STAMP_BITS-1:0] stamp,
                             input logic [FRAME_TAG_BITS-1:0] tag);
        t_in_item it;
        it.action    = action;
        it.stamp_ns  = stamp;
        it.frame_tag = tag;
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        track_arrival(it);
    endtask

    // no item in flight: every result back, then the longest match latency
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_batch(input logic [BATCH_BITS-1:0] value);
        logic [PDATA_BITS-1:0] word;
        word = $urandom;
        word[BATCH_BITS-1:0] = value;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BATCH_SIZE, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        batch_now = value;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== PDATA_BITS'(value)) begin
            $error("batch_size readback: expected %0h, actual %0h", value, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_matches.size() == 0) begin
                $error("match result with none expected: pose_tag %0h depth_tag %0h",
                       out_item.pose_tag, out_item.depth_tag);
                errors++;
            end else begin
                want = expected_matches.pop_front();
                matched++;
                if (out_item.pose_tag !== want.pose_tag) begin
                    $error("pose_tag: expected %0h, actual %0h",
                           want.pose_tag, out_item.pose_tag);
                    errors++;
                end
                if (out_item.depth_tag !== want.depth_tag) begin
                    $error("depth_tag: expected %0h, actual %0h",
                           want.depth_tag, out_item.depth_tag);
                    errors++;
                end
                if (out_item.time_difference_ns !== want.time_difference_ns) begin
                    $error("time_difference_ns: expected %0d, actual %0d",
                           want.time_difference_ns, out_item.time_difference_ns);
                    errors++;
                end
            end
        end
    end

    // reset batch of 5: first attempt finds no pose, second has a tie
    task automatic test_empty_queue_and_tie();
        send_item(ACTION_DEPTH, '0, 16'h0000);
        send_item(ACTION_DEPTH, STAMP_MAX, 16'hffff);
        send_item(ACTION_DEPTH, 63'd900, 16'h0001);
        send_item(ACTION_DEPTH, 63'd1100, 16'h0002);
        send_item(ACTION_DEPTH, 63'd5, 16'h0003);
        send_item(ACTION_POSE, 63'd1000, 16'hffff);
        send_item(ACTION_POSE, STAMP_MAX, 16'h0000);
        send_item(ACTION_POSE, '0, 16'h5a5a);
        send_item(ACTION_POSE, 63'd1, 16'ha5a5);
        send_item(ACTION_POSE, STAMP_MAX - 63'd1, 16'h8000);
    endtask

    // pose queue fills and drops its oldest entry, one match per item
    task automatic test_pose_overflow();
        write_batch(8'd1);
        send_item(ACTION_POSE, 63'h2aaa_aaaa_aaaa_aaaa, 16'h1234);
        send_item(ACTION_POSE, 63'h5555_5555_5555_5555, 16'hedcb);
        send_item(ACTION_POSE, '0, 16'h0000);
        send_item(ACTION_POSE, STAMP_MAX, 16'hffff);
        send_item(ACTION_POSE, 63'd1000, 16'h0010);
        send_item(ACTION_POSE, 63'd2000, 16'h0011);
    endtask

    task automatic test_batch_zero();
        write_batch(8'd0);
        send_item(ACTION_DEPTH, 63'd1000, 16'h0020);
        send_item(ACTION_POSE, 63'd1000, 16'h0021);
    endtask

    // count left above the new batch size: next item matches at once
    task automatic test_batch_below_count();
        write_batch(8'd10);
        send_item(ACTION_DEPTH, 63'd3000, 16'h0030);
        send_item(ACTION_POSE, 63'd3100, 16'h0031);
        send_item(ACTION_DEPTH, 63'd3200, 16'h0032);
        send_item(ACTION_POSE, 63'd3300, 16'h0033);
        write_batch(8'd2);
        send_item(ACTION_DEPTH, 63'd1050, 16'h0034);
    endtask

    // mostly time-ordered sensor traffic on a coarse grid so ties occur,
    // with some items at random or extreme stamps
    task automatic run_stream(input logic [BATCH_BITS-1:0] batch, input int n_items,
                              input bit full_rate);
        logic [STAMP_BITS-1:0]     clock_ns;
        logic [STAMP_BITS-1:0]     stamp;
        logic [FRAME_TAG_BITS-1:0] pose_seq;
        logic [FRAME_TAG_BITS-1:0] depth_seq;
        logic [FRAME_TAG_BITS-1:0] tag;
        logic                      act;
        int                        pick;
        write_batch(batch);
        calm      = full_rate;
        clock_ns  = STAMP_BITS'({$urandom, $urandom});
        pose_seq  = FRAME_TAG_BITS'($urandom);
        depth_seq = FRAME_TAG_BITS'($urandom);
        for (int n = 0; n < n_items; n++) begin
            act  = ($urandom_range(1) == 1) ? ACTION_POSE : ACTION_DEPTH;
            pick = $urandom_range(99);
            if (pick < 85) begin
                clock_ns = clock_ns + STAMP_BITS'(100 * $urandom_range(1, 20));
                stamp = clock_ns + STAMP_BITS'(50 * $urandom_range(0, 20)) - 63'd500;
                if (act == ACTION_POSE) begin
                    pose_seq = pose_seq + 1'b1;
                    tag = pose_seq;
                end else begin
                    depth_seq = depth_seq + 1'b1;
                    tag = depth_seq;
                end
            end else begin
                if (pick < 90) stamp = '0;
                else if (pick < 95) stamp = STAMP_MAX;
                else stamp = STAMP_BITS'({$urandom, $urandom});
                tag = FRAME_TAG_BITS'($urandom);
            end
            send_item(act, stamp, tag);
        end
        calm = 1'b0;
    endtask

    task automatic test_random_batches();
        run_stream(8'd1,   140, 1'b1);
        run_stream(8'd255, 520, 1'b0);
        run_stream(8'd2,   130, 1'b0);
        run_stream(8'd3,   130, 1'b0);
        run_stream(BATCH_BITS'($urandom_range(1, 20)), 130, 1'b0);
        run_stream(8'd7,   130, 1'b0);
        run_stream(8'd10,  130, 1'b0);
        run_stream(8'd11,  130, 1'b0);
        run_stream(8'd1,   130, 1'b0);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue_and_tie();
        test_pose_overflow();
        test_batch_zero();
        test_batch_below_count();
        test_random_batches();

        wait_drained();
        $display("sent %0d pose/depth items, checked %0d match results", accepted, matched);
        $display("batch sizes 0, 1, 255 and several in between, queue overflow and ties");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
